FILE: sv/scoped_symbol_table_top_assert.svh
// Assertion macros for the scoped symbol table.
`ifndef SCOPED_SYMBOL_TABLE_TOP_ASSERT_SVH
`define SCOPED_SYMBOL_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SST_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SST_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SST_ASSERT(label, clk, rstn, prop, msg)
`define SST_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: sv/sst_pkg.sv
package sst_pkg;
    localparam int MAX_SCOPES_D    = 50;
    localparam int TABLE_ENTRIES_D = 64;
    localparam int NAME_BITS_D     = 32;
    localparam int VALUE_BITS_D    = 64;
    localparam int DEPTH_W         = 6;
    localparam int TAG_W           = 8;

    localparam logic [3:0] REQ_PUSH   = 4'd0;
    localparam logic [3:0] REQ_POP    = 4'd1;
    localparam logic [3:0] REQ_SET    = 4'd2;
    localparam logic [3:0] REQ_GSET   = 4'd3;
    localparam logic [3:0] REQ_DSET   = 4'd4;
    localparam logic [3:0] REQ_UNSET  = 4'd5;
    localparam logic [3:0] REQ_LOOKUP = 4'd6;
    localparam logic [3:0] REQ_TOPLK  = 4'd7;
    localparam logic [3:0] REQ_FILTER = 4'd8;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_LOCAL  = 2'd1;
    localparam logic [1:0] KIND_GLOBAL = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the request word
        logic scan_clr;  // reset scan pointer and match trackers
        logic scan_step; // compare the entry read last cycle
        logic read_hit;  // start a read of the found entry
        logic write_ent; // write the bound entry
        logic clr_valid; // clear the valid bit of the match
        logic finish;    // form the result word
    } sst_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic scan_done;
        logic hit;
    } sst_stat_t;
endpackage

FILE: sv/sst_ram.sv
module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: sv/sst_datapath.sv
`include "scoped_symbol_table_top_assert.svh"
module sst_datapath import sst_pkg::*; #(
    parameter int MAX_SCOPES    = MAX_SCOPES_D,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_D,
    parameter int NAME_BITS     = NAME_BITS_D,
    parameter int VALUE_BITS    = VALUE_BITS_D
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sst_cmd_t              cmd,
    output sst_stat_t             stat,
    input  logic [3:0]            in_req,
    input  logic [NAME_BITS-1:0]  in_name,
    input  logic                  in_dollar,
    input  logic                  in_ident,
    input  logic [DEPTH_W-1:0]    in_delta,
    input  logic [TAG_W-1:0]      in_tag,
    input  logic [VALUE_BITS-1:0] in_value,
    output logic [1:0]            res_status,
    output logic                  res_created,
    output logic [1:0]            res_kind,
    output logic [TAG_W-1:0]      res_tag,
    output logic [VALUE_BITS-1:0] res_value,
    output logic [DEPTH_W-1:0]    res_depth
);
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int KW = NAME_BITS + DEPTH_W;
    localparam int CW = 1 + TAG_W + VALUE_BITS;
    localparam logic [DEPTH_W-1:0] TOP_LIMIT = DEPTH_W'(MAX_SCOPES - 1);

    // Request word.
    logic [3:0]            req_reg;
    logic [NAME_BITS-1:0]  name_reg;
    logic                  dollar_reg, ident_reg;
    logic [DEPTH_W-1:0]    delta_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [DEPTH_W-1:0]    level_reg, level_next;

    // Valid bits and scan state.
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [AW:0]              ptr_reg;
    logic                     cmp_vld_reg;
    logic [AW-1:0]            cmp_idx_reg;
    logic                     hit_reg, free_vld_reg;
    logic [AW-1:0]            hit_idx_reg, free_idx_reg;
    logic [DEPTH_W-1:0]       hit_scope_reg;
    logic [DEPTH_W-1:0]       target_reg;
    logic [AW-1:0]            pop_idx_reg;

    logic [KW-1:0] key_rd;
    logic [CW-1:0] cont_rd;
    logic [NAME_BITS-1:0] rd_name;
    logic [DEPTH_W-1:0]   rd_scope;
    logic                 downward;
    logic [AW-1:0]        raddr, waddr;
    logic                 wr_en, key_we;

    assign rd_name  = key_rd[KW-1:DEPTH_W];
    assign rd_scope = key_rd[DEPTH_W-1:0];
    assign downward = (req_reg == REQ_LOOKUP) || (req_reg == REQ_FILTER);

    // Read address: the scan pointer, or the found entry for content reads.
    assign raddr  = cmd.read_hit ? hit_idx_reg : ptr_reg[AW-1:0];
    assign waddr  = hit_reg ? hit_idx_reg : free_idx_reg;
    // A bind writes only when it has a slot; a full table leaves every entry alone.
    assign wr_en  = cmd.write_ent && (hit_reg || free_vld_reg);
    assign key_we = wr_en && !hit_reg;

    sst_ram #(.WIDTH(KW), .DEPTH(TABLE_ENTRIES)) u_key_ram (
        .aclk(aclk), .we(key_we), .waddr(waddr),
        .wdata({name_reg, target_reg}), .raddr(raddr), .rdata(key_rd)
    );
    sst_ram #(.WIDTH(CW), .DEPTH(TABLE_ENTRIES)) u_cont_ram (
        .aclk(aclk), .we(wr_en), .waddr(waddr),
        .wdata({(req_reg == REQ_GSET), tag_reg, value_reg}),
        .raddr(raddr), .rdata(cont_rd)
    );

    assign stat.scan_done = ptr_reg[AW] && !cmp_vld_reg;
    assign stat.hit       = hit_reg;

    // Scope level after the implicit or explicit level change of the request.
    always_comb begin
        level_next = level_reg;
        if (cmd.load) begin
            level_next = level_reg;
        end else if (cmd.scan_clr) begin
            case (req_reg)
                REQ_PUSH: if (level_reg < TOP_LIMIT) level_next = level_reg + 1'b1;
                REQ_POP:  if (level_reg != '0) level_next = level_reg - 1'b1;
                REQ_SET, REQ_GSET, REQ_DSET:
                    if (!dollar_reg && level_reg == '0) level_next = DEPTH_W'(1);
                default: level_next = level_reg;
            endcase
        end
    end

    logic match;
    always_comb begin
        match = 1'b0;
        if (cmp_vld_reg && valid_reg[cmp_idx_reg] && rd_name == name_reg) begin
            if (downward) match = (rd_scope < level_reg) && (!hit_reg || rd_scope > hit_scope_reg);
            else          match = (rd_scope == target_reg) && !hit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg   <= DEPTH_W'(1);
            valid_reg   <= '0;
            ptr_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            free_vld_reg <= 1'b0;
        end else begin
            level_reg <= level_next;
            if (cmd.load) begin
                req_reg    <= in_req;
                name_reg   <= in_name;
                dollar_reg <= in_dollar;
                ident_reg  <= in_ident;
                delta_reg  <= in_delta;
                tag_reg    <= in_tag;
                value_reg  <= in_value;
            end
            if (cmd.scan_clr) begin
                ptr_reg      <= '0;
                cmp_vld_reg  <= 1'b0;
                hit_reg      <= 1'b0;
                free_vld_reg <= 1'b0;
                // Target scope for sets, unset and top lookup.
                case (req_reg)
                    REQ_GSET: target_reg <= '0;
                    REQ_DSET: target_reg <= (level_next <= delta_reg) ? '0
                                          : level_next - delta_reg - 1'b1;
                    default:  target_reg <= level_next - 1'b1;
                endcase
            end
            // One entry per cycle: read issued, compared the next cycle.
            if (cmd.scan_step) begin
                if (!ptr_reg[AW]) begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
                cmp_vld_reg <= !ptr_reg[AW];
                cmp_idx_reg <= ptr_reg[AW-1:0];
                if (cmp_vld_reg) begin
                    if (req_reg == REQ_POP) begin
                        if (valid_reg[cmp_idx_reg] && rd_scope == level_reg)
                            valid_reg[cmp_idx_reg] <= 1'b0;
                    end else begin
                        if (match) begin
                            hit_reg       <= 1'b1;
                            hit_idx_reg   <= cmp_idx_reg;
                            hit_scope_reg <= rd_scope;
                        end
                        if (!valid_reg[cmp_idx_reg] && !free_vld_reg) begin
                            free_vld_reg <= 1'b1;
                            free_idx_reg <= cmp_idx_reg;
                        end
                    end
                end
            end
            if (key_we && free_vld_reg) begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (cmd.clr_valid && hit_reg) begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end
        end
    end

    // Result word.
    logic [1:0] kind;
    logic       glob;
    assign glob = cont_rd[CW-1];
    assign kind = !hit_reg ? KIND_NONE : (glob ? KIND_GLOBAL : KIND_LOCAL);

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            res_status  <= ST_OK;
            res_created <= 1'b0;
            res_kind    <= KIND_NONE;
            res_tag     <= '0;
            res_value   <= '0;
            res_depth   <= level_reg;
            case (req_reg)
                REQ_PUSH: begin
                    if (level_reg >= TOP_LIMIT && pop_idx_reg == '0) res_status <= ST_OVERFLOW;
                end
                REQ_SET, REQ_GSET, REQ_DSET: begin
                    if (!dollar_reg) begin
                        if (hit_reg) begin
                            res_status <= ST_OK;
                        end else if (free_vld_reg) begin
                            res_created <= 1'b1;
                        end else begin
                            res_status <= ST_FULL;
                        end
                    end
                end
                REQ_LOOKUP, REQ_TOPLK, REQ_FILTER: begin
                    res_tag   <= tag_reg;
                    res_value <= value_reg;
                    if (req_reg == REQ_FILTER || ident_reg) begin
                        res_kind <= kind;
                        if (hit_reg && (req_reg != REQ_FILTER || !glob)) begin
                            res_tag   <= cont_rd[CW-2:VALUE_BITS];
                            res_value <= cont_rd[VALUE_BITS-1:0];
                        end
                    end
                end
                default: res_status <= ST_OK;
            endcase
        end
    end

    // Push marker: set when a push is taken below the limit; overflow is flagged when it is clear.
    always_ff @(posedge aclk) begin
        if (cmd.scan_clr) begin
            pop_idx_reg <= (req_reg == REQ_PUSH && level_reg < TOP_LIMIT) ? AW'(1) : '0;
        end
    end

    `SST_ASSERT(a_level_range, aclk, aresetn, level_reg < DEPTH_W'(MAX_SCOPES), "scope level out of range")
    `SST_ASSERT(a_ptr_range, aclk, aresetn, ptr_reg <= (AW+1)'(TABLE_ENTRIES), "scan pointer past table")
    `SST_ASSERT(a_write_has_slot, aclk, aresetn, key_we |-> !valid_reg[free_idx_reg], "new binding over a live entry")
endmodule

FILE: sv/sst_ctrl.sv
`include "scoped_symbol_table_top_assert.svh"
module sst_ctrl import sst_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  logic [3:0] req,
    input  logic       dollar,
    input  sst_stat_t  stat,
    output sst_cmd_t   cmd
);
    typedef enum logic [2:0] {IDLE, PREP, SCAN, READ, ACT, DONE} state_t;
    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic [3:0] req_reg;
    logic       dollar_reg;
    logic       needs_scan, is_set;

    assign is_set  = (req_reg == REQ_SET) || (req_reg == REQ_GSET) || (req_reg == REQ_DSET);
    assign needs_scan = (req_reg == REQ_POP) || ((is_set || req_reg == REQ_UNSET) && !dollar_reg)
                      || req_reg == REQ_LOOKUP || req_reg == REQ_TOPLK || req_reg == REQ_FILTER;
    // A new word is taken in IDLE once the output slot is free or being drained.
    assign s_ready = (state_reg == IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            IDLE: if (s_valid && s_ready) begin
                cmd.load   = 1'b1;
                state_next = PREP;
            end
            PREP: begin
                cmd.scan_clr = 1'b1;
                state_next   = needs_scan ? SCAN : DONE;
            end
            SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) state_next = READ;
            end
            READ: begin
                cmd.read_hit = 1'b1;
                state_next   = ACT;
            end
            ACT: begin
                cmd.write_ent = is_set && !dollar_reg;
                cmd.clr_valid = (req_reg == REQ_UNSET) && !dollar_reg;
                cmd.finish    = 1'b1;
                m_valid_next  = 1'b1;
                state_next    = IDLE;
            end
            DONE: begin
                cmd.finish   = 1'b1;
                m_valid_next = 1'b1;
                state_next   = IDLE;
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cmd.load) begin
                req_reg    <= req;
                dollar_reg <= dollar;
            end
        end
    end

    `SST_ASSERT(a_one_out, aclk, aresetn, (state_reg == ACT || state_reg == DONE) |-> (!m_valid_reg || m_ready), "result overwritten")
    `SST_ASSERT(a_load_idle, aclk, aresetn, cmd.load |=> state_reg == PREP, "load without prep")
    `SST_ASSERT(a_busy, aclk, aresetn, (state_reg != IDLE) |-> !s_ready, "accepted while busy")
endmodule

FILE: sv/scoped_symbol_table_top.sv
// Scoped symbol table: name bindings held in nested scopes.
// Input channel s_*: one request word per handshake (s_valid/s_ready).
// Result channel m_*: one result word per request (m_valid/m_ready).
// Every request is served one at a time. Push, unknown codes, and sets or
// unset on the dollar name go from PREP straight to DONE, which raises
// m_valid. Requests that search the table (pop, set, unset, lookups,
// filter) walk it one entry per cycle through the key memory read port in
// SCAN, then pass through READ and ACT, which raises m_valid.
// A new request is taken once the block is idle and its output register
// is empty or being read in that cycle, so with no stall the next word can
// be accepted on the edge that takes the result. A stalled receiver holds
// the result and blocks the next request until it is taken.
// Reset (aresetn low, synchronous) sets the scope depth to 1 and empties
// the table at once through per-entry valid flags; no clearing pass.
module scoped_symbol_table_top import sst_pkg::*; #(
    parameter int MAX_SCOPES    = MAX_SCOPES_D,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_D,
    parameter int NAME_BITS     = NAME_BITS_D,
    parameter int VALUE_BITS    = VALUE_BITS_D
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [3:0]            s_req_type,
    input  logic [NAME_BITS-1:0]  s_name_key,
    input  logic                  s_name_is_dollar,
    input  logic                  s_is_identifier,
    input  logic [DEPTH_W-1:0]    s_depth_delta,
    input  logic [TAG_W-1:0]      s_content_tag,
    input  logic [VALUE_BITS-1:0] s_content_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic                  m_created,
    output logic [1:0]            m_found_kind,
    output logic [TAG_W-1:0]      m_out_tag,
    output logic [VALUE_BITS-1:0] m_out_value,
    output logic [DEPTH_W-1:0]    m_scope_depth
);
    sst_cmd_t  cmd;
    sst_stat_t stat;

    sst_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .req(s_req_type),
        .dollar(s_name_is_dollar), .stat(stat), .cmd(cmd)
    );

    sst_datapath #(
        .MAX_SCOPES(MAX_SCOPES), .TABLE_ENTRIES(TABLE_ENTRIES),
        .NAME_BITS(NAME_BITS), .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_req(s_req_type), .in_name(s_name_key), .in_dollar(s_name_is_dollar),
        .in_ident(s_is_identifier), .in_delta(s_depth_delta),
        .in_tag(s_content_tag), .in_value(s_content_data),
        .res_status(m_status), .res_created(m_created), .res_kind(m_found_kind),
        .res_tag(m_out_tag), .res_value(m_out_value), .res_depth(m_scope_depth)
    );
endmodule
